[design/deq_pkg.sv]
package deq_pkg;

	localparam int REQ_W   = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   pop_valid;
		logic   from_back;
		logic   overflow;
		logic   front_hit;
		logic   back_hit;
		value_t wdata;
	} rd_stage_t;

endpackage

[design/double_ended_queue.sv]
// channel  dir  handshake            fields
// in       in   in_valid/in_ready    req_type, push_value
// out      out  out_valid/out_ready  pop_valid, pop_value, overflow, count, is_empty,
//                                    front_value, back_value
// one request per cycle while out is taken; the store read registers at the transfer edge,
// and the result registers load from the read stage when out is empty or being taken
// reset clears pointers, count and valid flags; store contents are left as they are
// a stalled out holds the result and the read stage, and in_ready drops once both are full
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [REQ_W-1:0]          req_type,
	input  logic signed [VALUE_W-1:0] push_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      pop_valid,
	output logic signed [VALUE_W-1:0] pop_value,
	output logic                      overflow,
	output logic [COUNT_W-1:0]        count,
	output logic                      is_empty,
	output logic signed [VALUE_W-1:0] front_value,
	output logic signed [VALUE_W-1:0] back_value
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic [AW-1:0] front_q, back_q, front_n, back_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          accept, advance;
	logic          full, empty;
	logic          we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	rd_stage_t     rd_n, rd_s1;
	logic          valid_s1;
	logic [CW-1:0] cnt_s1;
	value_t        rdata_a, rdata_b;
	value_t        res_front, res_back, res_pop;
	value_t        last_front_q, last_back_q;

	logic          out_valid_q, pop_valid_q, overflow_q, is_empty_q;
	value_t        pop_value_q, front_value_q, back_value_q;
	logic [CW-1:0] cnt_out_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;

	// next pointers, count and store write for the request at the port
	always_comb begin
		front_n = front_q;
		back_n  = back_q;
		cnt_n   = cnt_q;
		we      = 1'b0;
		waddr   = back_q;
		rd_n    = '0;
		unique case (req_type)
			REQ_PUSH_FRONT: begin
				if (full) begin
					rd_n.overflow = 1'b1;
				end else begin
					front_n = idx_dec(front_q);
					waddr   = front_n;
					we      = 1'b1;
					cnt_n   = cnt_q + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					rd_n.overflow = 1'b1;
				end else begin
					waddr  = back_q;
					back_n = idx_inc(back_q);
					we     = 1'b1;
					cnt_n  = cnt_q + 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (!empty) begin
					front_n        = idx_inc(front_q);
					cnt_n          = cnt_q - 1'b1;
					rd_n.pop_valid = 1'b1;
				end
			end
			REQ_POP_BACK: begin
				if (!empty) begin
					back_n         = idx_dec(back_q);
					cnt_n          = cnt_q - 1'b1;
					rd_n.pop_valid = 1'b1;
					rd_n.from_back = 1'b1;
				end
			end
			default: begin
			end
		endcase
		raddr_a        = front_n;
		raddr_b        = idx_dec(back_n);
		rd_n.front_hit = we && (waddr == raddr_a);
		rd_n.back_hit  = we && (waddr == raddr_b);
		rd_n.wdata     = push_value;
	end

	deq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_deq_ram (
		.clk     (clk),
		.we      (accept && we),
		.waddr   (waddr),
		.wdata   (push_value),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_n;
				back_q  <= back_n;
				cnt_q   <= cnt_n;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= rd_n;
			cnt_s1 <= cnt_n;
		end
	end

	// same-cycle write bypass, front and back zeroed when empty, and pop values from the previous result
	always_comb begin
		res_front = rd_s1.front_hit ? rd_s1.wdata : rdata_a;
		res_back  = rd_s1.back_hit ? rd_s1.wdata : rdata_b;
		if (cnt_s1 == '0) begin
			res_front = '0;
			res_back  = '0;
		end
		res_pop = '0;
		if (rd_s1.pop_valid) begin
			res_pop = rd_s1.from_back ? last_back_q : last_front_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pop_valid_q   <= rd_s1.pop_valid;
			pop_value_q   <= res_pop;
			overflow_q    <= rd_s1.overflow;
			cnt_out_q     <= cnt_s1;
			is_empty_q    <= cnt_s1 == '0;
			front_value_q <= res_front;
			back_value_q  <= res_back;
			last_front_q  <= res_front;
			last_back_q   <= res_back;
		end
	end

	assign out_valid   = out_valid_q;
	assign pop_valid   = pop_valid_q;
	assign pop_value   = pop_value_q;
	assign overflow    = overflow_q;
	assign count       = COUNT_W'(cnt_out_q);
	assign is_empty    = is_empty_q;
	assign front_value = front_value_q;
	assign back_value  = back_value_q;

endmodule

[design/deq_ram.sv]
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [WIDTH-1:0]           rdata_a,
	output logic [WIDTH-1:0]           rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[design/deq_checker.sv]
module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [REQ_W-1:0]          req_type,
	input logic signed [VALUE_W-1:0] push_value,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      pop_valid,
	input logic signed [VALUE_W-1:0] pop_value,
	input logic                      overflow,
	input logic [COUNT_W-1:0]        count,
	input logic                      is_empty,
	input logic signed [VALUE_W-1:0] front_value,
	input logic signed [VALUE_W-1:0] back_value
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(push_value))
		else $error("input changed before transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(count)
			&& $stable(front_value) && $stable(back_value))
		else $error("result changed before transfer");

	a_pop_or_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pop_valid && overflow) && (pop_valid || pop_value == '0))
		else $error("pop and overflow flags inconsistent");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> front_value == '0 && back_value == '0 && !overflow)
		else $error("empty result carries values");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> count == COUNT_W'(DEPTH))
		else $error("overflow reported below capacity");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

[tb/double_ended_queue_tb.sv]
module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int DEPTH = 1024;
	localparam value_t RAIL_VALUES [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0};

	typedef struct {
		logic               pop_valid;
		value_t             pop_value;
		logic               overflow;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		value_t             front_value;
		value_t             back_value;
	} deque_result_t;

	typedef enum {FILL, DRAIN, MIXED} phase_t;

	class deque_scoreboard;
		value_t        slots [DEPTH];
		int unsigned   head;
		int unsigned   tail;
		int unsigned   held;
		deque_result_t due [$];
		int            errors;

		function new();
			head = 0;
			tail = 0;
			held = 0;
			errors = 0;
		endfunction

		// advance the deque state by one transfer and queue the result it must give
		function void note_request(logic [REQ_W-1:0] req, value_t val);
			deque_result_t r;
			r.pop_valid = 1'b0;
			r.pop_value = '0;
			r.overflow = 1'b0;
			r.front_value = '0;
			r.back_value = '0;
			case (req)
			REQ_PUSH_FRONT: begin
				if (held == DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					head = (head + DEPTH - 1) % DEPTH;
					slots[head] = val;
					held++;
				end
			end
			REQ_PUSH_BACK: begin
				if (held == DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					slots[tail] = val;
					tail = (tail + 1) % DEPTH;
					held++;
				end
			end
			REQ_POP_FRONT: begin
				if (held != 0) begin
					r.pop_valid = 1'b1;
					r.pop_value = slots[head];
					head = (head + 1) % DEPTH;
					held--;
				end
			end
			REQ_POP_BACK: begin
				if (held != 0) begin
					r.pop_valid = 1'b1;
					tail = (tail + DEPTH - 1) % DEPTH;
					r.pop_value = slots[tail];
					held--;
				end
			end
			default: ;
			endcase
			r.count = COUNT_W'(held);
			r.is_empty = (held == 0);
			if (held != 0) begin
				r.front_value = slots[head];
				r.back_value = slots[(tail + DEPTH - 1) % DEPTH];
			end
			due.insert(due.size(), r);
		endfunction

		function void check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(deque_result_t got);
			deque_result_t want;
			if (due.size() == 0) begin
				$display("%0t: result with none outstanding, expected nothing got count %0d",
					$time, got.count);
				errors++;
				return;
			end
			want = due[0];
			due.delete(0);
			check_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
			check_field("pop_value", want.pop_value, got.pop_value);
			check_field("overflow", 32'(want.overflow), 32'(got.overflow));
			check_field("count", 32'(want.count), 32'(got.count));
			check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
			check_field("front_value", want.front_value, got.front_value);
			check_field("back_value", want.back_value, got.back_value);
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [REQ_W-1:0]          req_type;
	logic signed [VALUE_W-1:0] push_value;
	logic                      out_valid;
	logic                      out_ready;
	logic                      pop_valid;
	logic signed [VALUE_W-1:0] pop_value;
	logic                      overflow;
	logic [COUNT_W-1:0]        count;
	logic                      is_empty;
	logic signed [VALUE_W-1:0] front_value;
	logic signed [VALUE_W-1:0] back_value;

	logic            steady;
	deque_scoreboard sb;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pop_valid(pop_valid),
		.pop_value(pop_value),
		.overflow(overflow),
		.count(count),
		.is_empty(is_empty),
		.front_value(front_value),
		.back_value(back_value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(0, 99) >= 29);
		end
	end

	always @(posedge clk) begin
		deque_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.pop_valid = pop_valid;
			got.pop_value = pop_value;
			got.overflow = overflow;
			got.count = count;
			got.is_empty = is_empty;
			got.front_value = front_value;
			got.back_value = back_value;
			sb.check_result(got);
		end
	end

	// present one request and hold it until the transfer
	task automatic send(input logic [REQ_W-1:0] req, input value_t val);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		push_value <= val;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, val);
	endtask

	initial begin
		int               n;
		int               spill;
		int               push_bias;
		phase_t           phase;
		logic [REQ_W-1:0] req;
		value_t           val;

		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PEEK;
		push_value = '0;
		steady = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue pops and peeks
		send(REQ_POP_FRONT, 32'h1234_5678);
		send(REQ_POP_BACK, 32'hffff_ffff);
		send(REQ_PEEK, 32'h0);
		// extremes at both ends, front pushes wrap below slot zero
		send(REQ_PUSH_BACK, 32'h7fff_ffff);
		send(REQ_PUSH_FRONT, 32'h8000_0000);
		send(REQ_PUSH_BACK, 32'hffff_ffff);
		send(REQ_PUSH_FRONT, 32'h0);
		send(REQ_PUSH_BACK, 32'h1);
		send(REQ_PEEK, 32'hdead_beef);
		// unknown request codes behave as a peek
		send(REQ_PEEK | 3'd1, 32'h5555_5555);
		send(REQ_PEEK | 3'd2, 32'haaaa_aaaa);
		send(REQ_PEEK | 3'd3, 32'hffff_ffff);
		send(REQ_POP_FRONT, 32'h0);
		send(REQ_POP_BACK, 32'h0);
		send(REQ_POP_BACK, 32'h0);
		send(REQ_POP_FRONT, 32'h0);
		send(REQ_POP_BACK, 32'h0);
		send(REQ_POP_BACK, 32'h0);
		send(REQ_PUSH_FRONT, 32'h5555_5555);
		send(REQ_PUSH_BACK, 32'haaaa_aaaa);
		send(REQ_POP_FRONT, 32'h0);
		send(REQ_POP_FRONT, 32'h0);
		send(REQ_POP_FRONT, 32'h0);

		// fill to full and overflow, drain to empty, then mixed traffic
		n = 0;
		spill = 0;
		phase = FILL;
		while (n < 2300 || phase != MIXED) begin
			steady = (n >= 300 && n < 700);
			push_bias = (phase == FILL) ? 99 : (phase == DRAIN) ? 1 : 50;
			if ($urandom_range(0, 99) < 3)
				req = REQ_PEEK | 3'($urandom_range(0, 3));
			else if ($urandom_range(0, 99) < push_bias)
				req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
			if ($urandom_range(0, 9) == 0)
				val = RAIL_VALUES[$urandom_range(0, 3)];
			else
				val = $urandom;
			send(req, val);
			n++;
			if (phase == FILL) begin
				if (sb.held == DEPTH)
					spill++;
				if (spill >= 16) begin
					phase = DRAIN;
					spill = 0;
				end
			end else if (phase == DRAIN) begin
				if (sb.held == 0)
					spill++;
				if (spill >= 16)
					phase = MIXED;
			end
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[double_ended_queue.f]
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
design/deq_checker.sv
tb/double_ended_queue_tb.sv
